>>> rtl/core/bsmh_pkg.sv
// ----------------------------------------------------------------------------
// Byte stream mixing hash package
// Constants and the item type handed from the per-byte mixer to the
// finishing pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmh_pkg;

    localparam int unsigned HashW = 64;
    localparam int unsigned NarrowW = 32;
    localparam int unsigned ByteW = 8;

    // Per-byte update constants.
    localparam logic [NarrowW-1:0] XOR_NARROW = 32'h0000_00ff;
    localparam logic [HashW-1:0] XOR_WIDE = 64'h0000_0000_0000_ffff;
    localparam logic [HashW-1:0] WIDE_LIMIT = 64'h0000_0000_ff00_0000;
    localparam logic [HashW-1:0] WIDE_ADD = 64'h00ff_ffff_ffff_ffff;
    localparam logic [HashW-1:0] WIDE_TOP_FLIP = 64'hff00_0000_0000_0000;

    // One finished message on its way through the avalanche stages.
    typedef struct packed {
        logic [HashW-1:0] hash;
        logic [ByteW-1:0] rev;
        logic wide;
    } bsmh_fin_t;

endpackage

`default_nettype wire

>>> rtl/core/bsmh_mix.sv
// ----------------------------------------------------------------------------
// Byte stream mixing hash: per-byte mixer
// Holds one input item, seeds the hash on the first byte of a message and
// applies the add, shift and xor update. A last item is passed on to the
// finishing pipeline through a registered hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmh_mix
    import bsmh_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [ByteW-1:0] in_byte,
    input  wire logic             in_last,
    input  wire logic             wide_mode,
    output logic                  fin_valid,
    input  wire logic             fin_ready,
    output bsmh_fin_t             fin_item
);

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;
    logic [HashW-1:0] running_hash_reg;
    logic [ByteW-1:0] first_rev_reg;
    logic             in_message_reg;
    logic             fin_valid_reg;
    bsmh_fin_t        fin_item_reg;

    logic             fin_free;
    logic             in_go;
    logic [ByteW-1:0] rev_now;
    logic [ByteW-1:0] rev_use;
    logic [HashW-1:0] h_in;
    logic [NarrowW-1:0] h32;
    logic [NarrowW-1:0] s32;
    logic [NarrowW-1:0] x32;
    logic [HashW-1:0] s64;
    logic [HashW-1:0] x64;
    logic [HashW-1:0] y64;
    logic [HashW-1:0] mixed;

    // Handshake: an item that ends no message never waits for the hand-off.
    assign fin_free = !fin_valid_reg || fin_ready;
    assign in_go    = in_valid_reg && (!in_last_reg || fin_free);
    assign in_ready = !in_valid_reg || in_go;

    // Bit reversal of the held byte.
    always_comb
    begin
        for (int i = 0; i < ByteW; i++)
        begin
            rev_now[i] = in_byte_reg[ByteW-1-i];
        end
    end

    assign rev_use = in_message_reg ? first_rev_reg : rev_now;
    assign h_in    = in_message_reg ? running_hash_reg : {{(HashW-ByteW){1'b0}}, rev_now};

    // Narrow update, modulo 2^32.
    assign h32 = h_in[NarrowW-1:0];
    assign s32 = h32 + ({{(NarrowW-ByteW-7){1'b0}}, in_byte_reg, 7'b0}
                        | {15'b0, h32[NarrowW-1:15]});
    assign x32 = s32 ^ (s32 >> 6) ^ XOR_NARROW;

    // Wide update, modulo 2^64, with the low-value correction.
    assign s64 = h_in + ({{(HashW-ByteW-7){1'b0}}, in_byte_reg, 7'b0}
                         | {31'b0, h_in[HashW-1:31]});
    assign x64 = s64 ^ (s64 >> 6) ^ XOR_WIDE;

    always_comb
    begin
        if (x64 <= WIDE_LIMIT)
        begin
            y64 = (x64 + WIDE_ADD) ^ WIDE_TOP_FLIP;
        end
        else
        begin
            y64 = x64;
        end
    end

    assign mixed = wide_mode ? y64 : {{(HashW-NarrowW){1'b0}}, x32};

    // Input register, message state and the hand-off register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            in_byte_reg      <= '0;
            in_last_reg      <= 1'b0;
            running_hash_reg <= '0;
            first_rev_reg    <= '0;
            in_message_reg   <= 1'b0;
            fin_valid_reg    <= 1'b0;
            fin_item_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
                in_byte_reg  <= in_byte;
                in_last_reg  <= in_last;
            end
            if (in_go)
            begin
                first_rev_reg <= rev_use;
                if (in_last_reg)
                begin
                    running_hash_reg <= '0;
                    in_message_reg   <= 1'b0;
                end
                else
                begin
                    running_hash_reg <= mixed;
                    in_message_reg   <= 1'b1;
                end
            end
            if (fin_free)
            begin
                fin_valid_reg <= in_go && in_last_reg;
                fin_item_reg  <= '{hash: mixed, rev: rev_use, wide: wide_mode};
            end
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_item  = fin_item_reg;

endmodule

`default_nettype wire

>>> rtl/core/bsmh_final.sv
// ----------------------------------------------------------------------------
// Byte stream mixing hash: finishing pipeline
// Two stages of final avalanche, then the reversed first byte is added and
// the result is masked to the selected width in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmh_final
    import bsmh_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fin_valid,
    output logic                  fin_ready,
    input  wire bsmh_fin_t        fin_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [HashW-1:0]      out_hash
);

    logic             f1_valid_reg;
    bsmh_fin_t        f1_item_reg;
    logic             out_valid_reg;
    logic [HashW-1:0] out_hash_reg;

    logic             out_free;
    logic             f1_free;
    logic [HashW-1:0] mask_in;
    logic [HashW-1:0] mask_f1;
    logic [HashW-1:0] h1;
    logic [HashW-1:0] h2;
    logic [HashW-1:0] h3;

    assign out_free  = !out_valid_reg || out_ready;
    assign f1_free   = !f1_valid_reg || out_free;
    assign fin_ready = f1_free;

    assign mask_in = fin_item.wide ? {HashW{1'b1}} : {{(HashW-NarrowW){1'b0}}, {NarrowW{1'b1}}};
    assign mask_f1 = f1_item_reg.wide ? {HashW{1'b1}}
                                      : {{(HashW-NarrowW){1'b0}}, {NarrowW{1'b1}}};

    // First stage: h += h << 3, then h ^= h >> 11.
    assign h1 = (fin_item.hash + (fin_item.hash << 3)) & mask_in;
    assign h2 = h1 ^ (h1 >> 11);

    // Second stage: h += h << 15, then the reversed first byte is added.
    assign h3 = (f1_item_reg.hash + (f1_item_reg.hash << 15)
                 + {{(HashW-ByteW){1'b0}}, f1_item_reg.rev}) & mask_f1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f1_item_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_hash_reg  <= '0;
        end
        else
        begin
            if (f1_free)
            begin
                f1_valid_reg <= fin_valid;
                f1_item_reg  <= '{hash: h2, rev: fin_item.rev, wide: fin_item.wide};
            end
            if (out_free)
            begin
                out_valid_reg <= f1_valid_reg;
                out_hash_reg  <= h3;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;

endmodule

`default_nettype wire

>>> rtl/core/byte_stream_mixing_hash.sv
// ----------------------------------------------------------------------------
// Byte stream mixing hash
// Takes one byte item per cycle unless a last item waits for the hand-off;
// the per-byte feedback through the mixer sets that rate. The running hash
// is updated in the mixer and the item marked last, which passes the input,
// hand-off, first-stage and output registers, gives one 64-bit result.
// Reset clears the hash state and the mode (32-bit).
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_mixing_hash
    import bsmh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration: wide_mode (0 = 32-bit, 1 = 64-bit).
    input  wire logic              wide_mode_we,
    input  wire logic              wide_mode_wdata,
    // Byte input.
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [ByteW-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic              s_axis_tlast,   // last_byte
    // Hash output.
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [HashW-1:0]       m_axis_tdata    // [63:0] hash_value
);

    logic      wide_mode_reg;
    logic      fin_valid;
    logic      fin_ready;
    bsmh_fin_t fin_item;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg <= 1'b0;
        end
        else if (wide_mode_we)
        begin
            wide_mode_reg <= wide_mode_wdata;
        end
    end

    // Per-byte mixer.
    bsmh_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .wide_mode (wide_mode_reg),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_item  (fin_item)
    );

    // Final avalanche and output register.
    bsmh_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_item  (fin_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );

endmodule

`default_nettype wire
